[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros used by the pulse width reader top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCPW_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define RCPW_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

[hw/rtl/rcpw_pkg.sv]
// ----------------------------------------------------------------------------
// rcpw_pkg
// Types and constants of the RC pulse width reader.
// ----------------------------------------------------------------------------
package rcpw_pkg;

    localparam int NUM_CH    = 5;
    localparam int WIDTH_W   = 16;
    localparam int CFG_IDX_W = 3;

    // Channel positions in the mask and level vectors.
    localparam int CH_THROTTLE = 0;
    localparam int CH_ROLL     = 1;
    localparam int CH_PITCH    = 2;
    localparam int CH_YAW      = 3;
    localparam int CH_GEAR     = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_MIN         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_MAX         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_CENTER      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_DEADBAND    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_MIN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_MAX      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_DEADBAND = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_GEAR_THRESHOLD    = 3'd7;

    typedef struct packed {
        logic [4:0]  changed_mask;
        logic [4:0]  pin_levels;
        logic [31:0] timer_count;
    } in_item_t;

    typedef struct packed {
        logic [15:0] throttle_value;
        logic [15:0] roll_value;
        logic [15:0] pitch_value;
        logic [15:0] yaw_value;
        logic        gear_on;
        logic        range_error;
    } out_item_t;

    typedef struct packed {
        logic [15:0] stick_min;
        logic [15:0] stick_max;
        logic [15:0] stick_center;
        logic [15:0] stick_deadband;
        logic [15:0] throttle_min;
        logic [15:0] throttle_max;
        logic [15:0] throttle_deadband;
        logic [15:0] gear_threshold;
    } cfg_t;

    typedef logic [NUM_CH-1:0][WIDTH_W-1:0] width_vec_t;

endpackage

[hw/rtl/rcpw_capture.sv]
// ----------------------------------------------------------------------------
// rcpw_capture
// Per-channel edge detection, rise time latch and pulse width store.
// ----------------------------------------------------------------------------
module rcpw_capture
    import rcpw_pkg::*;
#(
    parameter int TIMER_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  in_item_t   item,
    output width_vec_t widths
);

    logic [NUM_CH-1:0]                 prior_reg;
    logic [NUM_CH-1:0]                 prior_next;
    logic [NUM_CH-1:0][TIMER_BITS-1:0] rise_reg;
    logic [NUM_CH-1:0][TIMER_BITS-1:0] rise_next;
    width_vec_t                        width_reg;
    width_vec_t                        width_next;

    logic [TIMER_BITS-1:0]             now;
    logic [NUM_CH-1:0][TIMER_BITS-1:0] diff;
    width_vec_t                        tick_w;

    assign now = item.timer_count[TIMER_BITS-1:0];

    always_comb
    begin
        prior_next = prior_reg;
        rise_next  = rise_reg;
        width_next = width_reg;
        for (int i = 0; i < NUM_CH; i++)
        begin
            // Without a later stop the count wraps one tick short, and equal
            // counts give all ones; both are stop - start - 1 modulo the timer.
            diff[i]   = now - rise_reg[i];
            tick_w[i] = diff[i][WIDTH_W-1:0]
                        - {{(WIDTH_W-1){1'b0}}, ~(now > rise_reg[i])};
            if (accept && item.changed_mask[i] && (item.pin_levels[i] != prior_reg[i]))
            begin
                prior_next[i] = item.pin_levels[i];
                if (item.pin_levels[i])
                begin
                    rise_next[i] = now;
                end
                else
                begin
                    width_next[i] = tick_w[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_reg <= '0;
            rise_reg  <= '0;
            width_reg <= '0;
        end
        else
        begin
            prior_reg <= prior_next;
            rise_reg  <= rise_next;
            width_reg <= width_next;
        end
    end

    assign widths = width_reg;

endmodule

[hw/rtl/rcpw_convert.sv]
// ----------------------------------------------------------------------------
// rcpw_convert
// Range checks and dead band handling that turn widths into control values.
// ----------------------------------------------------------------------------
module rcpw_convert
    import rcpw_pkg::*;
(
    input  width_vec_t widths,
    input  cfg_t       cfg,
    output out_item_t  result
);

    localparam int NUM_STICK = 3;

    logic [WIDTH_W-1:0]               thr_w;
    logic [WIDTH_W-1:0]               thr_off;
    logic                             thr_err;
    logic [WIDTH_W-1:0]               gear_w;
    logic [WIDTH_W-1:0]               gear_off;
    logic                             gear_err;
    logic signed [WIDTH_W+1:0]        band_lo;
    logic signed [WIDTH_W+1:0]        band_hi;
    logic [NUM_STICK-1:0][WIDTH_W-1:0] st_w;
    logic [NUM_STICK-1:0][WIDTH_W-1:0] st_off;
    logic [NUM_STICK-1:0][WIDTH_W-1:0] st_val;
    logic [NUM_STICK-1:0]             st_err;

    // The band bounds are exact: below zero or above full scale never clips.
    assign band_lo = $signed({2'b00, cfg.stick_center}) - $signed({2'b00, cfg.stick_deadband});
    assign band_hi = $signed({2'b00, cfg.stick_center}) + $signed({2'b00, cfg.stick_deadband});

    always_comb
    begin
        for (int i = 0; i < NUM_STICK; i++)
        begin
            st_w[i]   = widths[CH_ROLL + i];
            st_off[i] = st_w[i] - cfg.stick_min;
            st_err[i] = (st_w[i] < cfg.stick_min) || (st_w[i] > cfg.stick_max);
            if (st_err[i])
            begin
                st_val[i] = cfg.stick_center;
            end
            else if (($signed({2'b00, st_off[i]}) >= band_lo)
                     && ($signed({2'b00, st_off[i]}) <= band_hi))
            begin
                st_val[i] = cfg.stick_center;
            end
            else
            begin
                st_val[i] = st_off[i];
            end
        end
    end

    assign thr_w   = widths[CH_THROTTLE];
    assign thr_off = thr_w - cfg.throttle_min;
    assign thr_err = (thr_w < cfg.throttle_min) || (thr_w > cfg.throttle_max);

    assign gear_w   = widths[CH_GEAR];
    assign gear_off = gear_w - cfg.stick_min;
    assign gear_err = (gear_w < cfg.stick_min) || (gear_w > cfg.stick_max);

    always_comb
    begin
        result.throttle_value = (thr_err || (thr_off <= cfg.throttle_deadband))
                                ? '0 : thr_off;
        result.roll_value     = st_val[0];
        result.pitch_value    = st_val[1];
        result.yaw_value      = st_val[CH_YAW - CH_ROLL];
        result.gear_on        = !gear_err && (gear_off >= cfg.gear_threshold);
        result.range_error    = thr_err || gear_err || (|st_err);
    end

endmodule

[hw/rtl/rc_pulse_width_reader_top.sv]
// ----------------------------------------------------------------------------
// rc_pulse_width_reader_top
// Five-channel RC PWM pulse width reader with a configuration port.
// ----------------------------------------------------------------------------
// Usage:
//   Each input item carries a per-channel change mask, the pin levels and a
//   timer count. A rising edge on a flagged channel latches the count; a
//   falling edge stores the tick difference as that channel's pulse width.
//   Every item yields exactly one result item with the converted throttle,
//   roll, pitch and yaw values, the gear switch and a range error flag.
//   The edge logic updates the width store at the accepting edge, and the
//   conversion fills the output register from the width store once the
//   output can load, so a result passes the width store stage and the
//   output register before out_valid rises. Throughput is one item per
//   cycle while the receiver takes results, set by the width store update.
//   When the receiver stalls, the output register holds its item and one
//   more item may sit in the width store stage; after that in_ready drops.
//   Reset clears all widths, rise counts and pin histories to zero, empties
//   the pipeline and loads the register defaults (maxima 65535, the rest 0).
//   Configuration writes are registered; users make them only while idle (unenforced).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rc_pulse_width_reader_top
    import rcpw_pkg::*;
#(
    parameter int TIMER_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WIDTH_W-1:0]   cfg_wdata
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_item_t  out_data_reg;
    logic       in_accept;
    logic       out_load;
    width_vec_t widths;
    out_item_t  conv_result;

    assign out_load  = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || out_load;
    assign in_accept = in_valid && in_ready;

    rcpw_capture #(
        .TIMER_BITS (TIMER_BITS)
    ) u_capture (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_accept),
        .item   (in_data),
        .widths (widths)
    );

    rcpw_convert u_convert (
        .widths (widths),
        .cfg    (cfg_reg),
        .result (conv_result)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STICK_MIN:         cfg_next.stick_min         = cfg_wdata;
                CFG_STICK_MAX:         cfg_next.stick_max         = cfg_wdata;
                CFG_STICK_CENTER:      cfg_next.stick_center      = cfg_wdata;
                CFG_STICK_DEADBAND:    cfg_next.stick_deadband    = cfg_wdata;
                CFG_THROTTLE_MIN:      cfg_next.throttle_min      = cfg_wdata;
                CFG_THROTTLE_MAX:      cfg_next.throttle_max      = cfg_wdata;
                CFG_THROTTLE_DEADBAND: cfg_next.throttle_deadband = cfg_wdata;
                CFG_GEAR_THRESHOLD:    cfg_next.gear_threshold    = cfg_wdata;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = s1_valid_reg;
            s1_valid_next  = 1'b0;
        end
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '{stick_max: '1, throttle_max: '1, default: '0};
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The result is taken from the width store after its item's update.
    always_ff @(posedge clk)
    begin
        if (out_load && s1_valid_reg)
        begin
            out_data_reg <= conv_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `RCPW_ASSERT_IMP(a_ready_when_out_empty, clk, rst_n, !out_valid_reg, in_ready)
    `RCPW_ASSERT_NXT(a_widths_hold_when_full, clk, rst_n, !in_ready, $stable(widths))
    `RCPW_ASSERT_IMP(a_out_from_stage, clk, rst_n, $rose(out_valid_reg), $past(s1_valid_reg))

endmodule
